@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the serial link shift port.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define SLSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SLSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SLSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/slsp_pkg.sv @@
// Types and constants of the serial link shift port.
`timescale 1ns / 1ps

package slsp_pkg;

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 7;
    localparam int DIV_W   = 8;
    localparam int BCNT_W  = 4;

    localparam int SLOW_DIVIDE_DEF = 128;
    localparam int FAST_DIVIDE_DEF = 4;

    localparam logic [BCNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Control register layout
    localparam int CTRL_IC_BIT   = 0;
    localparam int CTRL_FAST_BIT = 1;
    localparam int CTRL_EN_BIT   = 7;
    localparam logic [BYTE_W-1:0] CTRL_FILL = 8'h7C;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_WR_CTRL  = 3'd1,
        CMD_RD_CTRL  = 3'd2,
        CMD_WR_DATA  = 3'd3,
        CMD_RD_DATA  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] wr_value;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_value;
        logic              irq_pulse;
        logic              byte_done;
        logic [BYTE_W-1:0] sent_byte;
    } t_result;

endpackage

@@ src/slsp_if.sv @@
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps

interface slsp_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [slsp_pkg::CMD_W-1:0]    cmd;
    logic [slsp_pkg::BYTE_W-1:0]   wr_value;

    modport source (output valid, output cmd, output wr_value, input ready);
    modport sink   (input valid, input cmd, input wr_value, output ready);
endinterface

interface slsp_res_if;
    logic                          valid;
    logic                          ready;
    logic [slsp_pkg::BYTE_W-1:0]   rd_value;
    logic                          irq_pulse;
    logic                          byte_done;
    logic [slsp_pkg::BYTE_W-1:0]   sent_byte;

    modport source (output valid, output rd_value, output irq_pulse, output byte_done,
                    output sent_byte, input ready);
    modport sink   (input valid, input rd_value, input irq_pulse, input byte_done,
                    input sent_byte, output ready);
endinterface

@@ src/slsp_in_reg.sv @@
// Input register stage: captures one command beat and holds it until it moves on.
`timescale 1ns / 1ps

module slsp_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  slsp_pkg::t_item     i_item,
    input  logic                i_advance,
    output logic                o_ready,
    output logic                o_valid,
    output slsp_pkg::t_item     o_item
);

    logic            r_valid;
    slsp_pkg::t_item r_item;

    // Take a beat when the stage is empty or its content moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the payload while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/slsp_core.sv @@
// Port state and the combinational update that one command beat makes to it.
`timescale 1ns / 1ps

module slsp_core #(
    parameter int SLOW_DIVIDE = slsp_pkg::SLOW_DIVIDE_DEF,
    parameter int FAST_DIVIDE = slsp_pkg::FAST_DIVIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  slsp_pkg::t_item     i_item,
    output slsp_pkg::t_result   o_result
);

    localparam int DW = slsp_pkg::DIV_W;
    localparam int CW = slsp_pkg::CNT_W;
    localparam int BW = slsp_pkg::BYTE_W;
    localparam int NW = slsp_pkg::BCNT_W;
    localparam logic [DW-1:0] SLOW_DIV = DW'(SLOW_DIVIDE);
    localparam logic [DW-1:0] FAST_DIV = DW'(FAST_DIVIDE);

    logic [CW-1:0] r_cnt,   n_cnt;
    logic          r_fast,  n_fast;
    logic          r_en,    n_en;
    logic          r_ic,    n_ic;
    logic [NW-1:0] r_bits,  n_bits;
    logic [BW-1:0] r_data,  n_data;
    logic [BW-1:0] r_sent,  n_sent;

    logic [DW-1:0] divide;
    logic [DW-1:0] cnt_inc;
    logic          wrap;
    slsp_pkg::t_result res;

    // Prescaler compare against the divide of the current mode
    assign divide  = r_fast ? FAST_DIV : SLOW_DIV;
    assign cnt_inc = {1'b0, r_cnt} + DW'(1);
    assign wrap    = (cnt_inc >= divide);

    // Decode the command and form the next state and the result
    always_comb begin
        n_cnt  = r_cnt;
        n_fast = r_fast;
        n_en   = r_en;
        n_ic   = r_ic;
        n_bits = r_bits;
        n_data = r_data;
        n_sent = r_sent;
        res    = '0;
        case (slsp_pkg::t_cmd'(i_item.cmd))
            slsp_pkg::CMD_TICK: begin
                if (wrap) begin
                    n_cnt = '0;
                    if (r_en && r_ic) begin
                        n_data = {r_data[BW-2:0], 1'b0};
                        n_sent = {r_sent[BW-2:0], r_data[BW-1]};
                        n_bits = r_bits + NW'(1);
                        if (n_bits == slsp_pkg::BITS_PER_BYTE) begin
                            n_en          = 1'b0;
                            res.irq_pulse = 1'b1;
                            res.byte_done = 1'b1;
                            res.sent_byte = n_sent;
                        end
                    end
                end else begin
                    n_cnt = cnt_inc[CW-1:0];
                end
            end
            slsp_pkg::CMD_WR_CTRL: begin
                n_ic   = i_item.wr_value[slsp_pkg::CTRL_IC_BIT];
                n_fast = i_item.wr_value[slsp_pkg::CTRL_FAST_BIT];
                n_en   = i_item.wr_value[slsp_pkg::CTRL_EN_BIT];
                // Restart the transfer when it is armed on the internal clock
                if (n_en && n_ic) begin
                    n_bits = '0;
                    n_sent = '0;
                end
            end
            slsp_pkg::CMD_RD_CTRL: begin
                res.rd_value = slsp_pkg::CTRL_FILL;
                res.rd_value[slsp_pkg::CTRL_EN_BIT]   = r_en;
                res.rd_value[slsp_pkg::CTRL_FAST_BIT] = r_fast;
                res.rd_value[slsp_pkg::CTRL_IC_BIT]   = r_ic;
            end
            slsp_pkg::CMD_WR_DATA: begin
                n_data = i_item.wr_value;
            end
            slsp_pkg::CMD_RD_DATA: begin
                res.rd_value = r_data;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // Commit the update only for a beat that moves on this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fast <= 1'b0;
            r_en   <= 1'b0;
            r_ic   <= 1'b0;
            r_bits <= '0;
            r_data <= '0;
            r_sent <= '0;
        end else if (i_valid) begin
            r_cnt  <= n_cnt;
            r_fast <= n_fast;
            r_en   <= n_en;
            r_ic   <= n_ic;
            r_bits <= n_bits;
            r_data <= n_data;
            r_sent <= n_sent;
        end
    end

    assign o_result = res;

endmodule

@@ src/serial_link_shift_port.sv @@
// Top level of the serial link shift port: input stage, state update and result register.
//
// Usage:
//   i_cmd carries one beat per machine cycle: a tick, a control write or read,
//   or a data write or read (cmd, wr_value). o_res returns exactly one beat for
//   every command beat, in order: rd_value for reads, and irq_pulse, byte_done
//   and sent_byte on the tick that shifts out the eighth bit of a transfer.
//   Path: the accepting edge loads the input register, and the beat moves on
//   into the result register on the edge at which that register frees up.
//   Throughput: one command per cycle unless o_res is held off; the whole state
//   update is combinational in slsp_core (prescaler compare, one-bit shift, bit count).
//   Stall: while o_res is held off, the result register keeps its beat and
//   the input register can still take one more command; i_cmd.ready drops
//   only when both are full.
//   Reset (i_rst_n low, synchronous): both stages empty, prescaler, control
//   bits, bit count, data and sent-bit registers all clear to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module serial_link_shift_port #(
    parameter int SLOW_DIVIDE = slsp_pkg::SLOW_DIVIDE_DEF,
    parameter int FAST_DIVIDE = slsp_pkg::FAST_DIVIDE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    slsp_cmd_if.sink       i_cmd,
    slsp_res_if.source     o_res
);

    slsp_pkg::t_item   in_item;
    slsp_pkg::t_item   st_item;
    logic              st_valid;
    logic              advance;
    slsp_pkg::t_result core_res;

    logic              r_out_valid;
    slsp_pkg::t_result r_out;

    assign in_item.cmd      = i_cmd.cmd;
    assign in_item.wr_value = i_cmd.wr_value;

    // Move a beat out of the input register whenever the result register frees up
    assign advance = !r_out_valid || o_res.ready;

    slsp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_cmd.ready),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    slsp_core #(
        .SLOW_DIVIDE (SLOW_DIVIDE),
        .FAST_DIVIDE (FAST_DIVIDE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (st_valid && advance),
        .i_item   (st_item),
        .o_result (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= st_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && st_valid) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.rd_value  = r_out.rd_value;
    assign o_res.irq_pulse = r_out.irq_pulse;
    assign o_res.byte_done = r_out.byte_done;
    assign o_res.sent_byte = r_out.sent_byte;

    // Checks
    `SLSP_ASSERT_IMP(a_done_is_irq, i_clk, i_rst_n, o_res.valid, o_res.byte_done == o_res.irq_pulse, "byte_done differs from irq_pulse")
    `SLSP_ASSERT_IMP(a_sent_only_done, i_clk, i_rst_n, o_res.valid && !o_res.byte_done, o_res.sent_byte == '0, "sent_byte set without a finished transfer")
    `SLSP_ASSERT_IMP(a_full_blocks, i_clk, i_rst_n, st_valid && o_res.valid && !o_res.ready, !i_cmd.ready, "command taken while both stages are full")
    `SLSP_ASSERT_NXT(a_stage_moves, i_clk, i_rst_n, st_valid && advance, o_res.valid, "staged beat lost on its way to the result register")

endmodule
